// ----- rtl/core/ctle_pkg.sv -----
// Package for the triangle level expander: codes, constants and control structs.
package ctle_pkg;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_ADV   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOW   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_HIGH  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_VALID = 8'd3;

	localparam logic [1:0] WINDOW_RESET = 2'd2;
	localparam logic [1:0] MAX_WINDOW   = 2'd3;
	localparam int         COUNT_W      = 7;

	typedef struct packed {
		logic start;
		logic rd;
		logic proc;
		logic mknew;
		logic emit;
	} ctle_cmd_t;

	typedef struct packed {
		logic start_walk;
		logic step_next;
		logic step_new;
		logic out_free;
	} ctle_sts_t;

endpackage

// ----- rtl/core/ctle_if.sv -----
// Channel interfaces: item input, result output and configuration write.
interface ctle_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [1:0] label;
	modport source (output valid, output op, output label, input ready);
	modport sink (input valid, input op, input label, output ready);
endinterface

interface ctle_rsp_if;
	logic       valid;
	logic       ready;
	logic       produced;
	logic [1:0] bottom_label;
	logic       no_match;
	logic       level_overflow;
	logic       not_ready;
	logic [6:0] level_count;
	modport source (output valid, output produced, output bottom_label, output no_match,
		output level_overflow, output not_ready, output level_count, input ready);
	modport sink (input valid, input produced, input bottom_label, input no_match,
		input level_overflow, input not_ready, input level_count, output ready);
endinterface

interface ctle_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [63:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/ctle_ctrl.sv -----
// Controller state machine: sequences the per-level walk and the result hand-off.
module ctle_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ctle_pkg::ctle_sts_t sts,
	output ctle_pkg::ctle_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_PROC = 3'd2;
	localparam logic [2:0] S_NEW  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.start = accept;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = sts.start_walk ? S_RD : S_DONE;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_PROC;
			end
			S_PROC: begin
				cmd.proc = 1'b1;
				priority if (sts.step_next) begin
					state_d = S_RD;
				end else if (sts.step_new) begin
					state_d = S_NEW;
				end else begin
					state_d = S_DONE;
				end
			end
			S_NEW: begin
				cmd.mknew = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/core/ctle_dp.sv -----
// Datapath: level memory, rule table lookup, configuration and result register.
module ctle_dp #(
	parameter int MAX_LEVELS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          req_op,
	input  logic [1:0]          req_label,
	ctle_cfg_if.sink            cfg,
	ctle_rsp_if.source          rsp,
	input  ctle_pkg::ctle_cmd_t cmd,
	output ctle_pkg::ctle_sts_t sts
);

	localparam int AW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int LCW = $clog2(MAX_LEVELS + 1);
	localparam logic [LCW-1:0] LEVEL_LIMIT = LCW'(MAX_LEVELS);

	// entry: fill in [7:6], newest three labels in [5:0], newest lowest
	logic [7:0]     lvl_mem_q [MAX_LEVELS];
	logic [7:0]     rdata_q;

	logic [1:0]     win_q;
	logic [63:0]    tab_lo_q;
	logic [63:0]    tab_hi_q;
	logic [63:0]    ent_v_q;

	logic [LCW-1:0] levels_q;
	logic           bsingle_q;
	logic           fresh_q;
	logic           ovalid_q;

	logic [AW-1:0]  lv_q;
	logic [1:0]     lab_q;
	logic [1:0]     blab_q;
	logic           prod_q;
	logic [1:0]     rlab_q;
	logic           nm_q;
	logic           ovf_q;
	logic           nr_q;

	logic           o_prod_q;
	logic [1:0]     o_blab_q;
	logic           o_nm_q;
	logic           o_ovf_q;
	logic           o_nr_q;
	logic [6:0]     o_cnt_q;

	logic [1:0]     w_eff;
	logic [5:0]     win_mask;
	logic [7:0]     entry;
	logic [5:0]     new_win;
	logic [1:0]     new_fill;
	logic [5:0]     nbhd;
	logic [63:0]    tab_sel;
	logic [1:0]     res;
	logic           need_lookup;
	logic           hit;
	logic [LCW-1:0] lv_ext;
	logic [LCW-1:0] lv_next;
	logic           is_bottom;
	logic [AW-1:0]  new_addr;
	logic [LCW+6:0] cnt_ext;

	assign cfg.ready = 1'b1;

	always_comb begin
		priority if (win_q == 2'd0) begin
			w_eff = 2'd1;
		end else if (win_q > ctle_pkg::MAX_WINDOW) begin
			w_eff = ctle_pkg::MAX_WINDOW;
		end else begin
			w_eff = win_q;
		end
		unique case (w_eff)
			2'd1:    win_mask = 6'h03;
			2'd2:    win_mask = 6'h0F;
			default: win_mask = 6'h3F;
		endcase
	end

	always_comb begin
		entry       = fresh_q ? 8'd0 : rdata_q;
		new_win     = {entry[3:0], lab_q};
		new_fill    = (entry[7:6] == 2'd3) ? 2'd3 : entry[7:6] + 2'd1;
		nbhd        = new_win & win_mask;
		tab_sel     = nbhd[5] ? tab_hi_q : tab_lo_q;
		res         = tab_sel[{nbhd[4:0], 1'b0} +: 2];
		need_lookup = (new_fill >= w_eff);
		hit         = need_lookup && ent_v_q[nbhd];
		lv_ext      = LCW'(lv_q);
		lv_next     = lv_ext + LCW'(1);
		is_bottom   = (lv_next == levels_q);
		new_addr    = lv_next[AW-1:0];
		cnt_ext     = {7'd0, levels_q};
	end

	assign sts.start_walk = (req_op == ctle_pkg::OP_PUSH)
		|| ((req_op == ctle_pkg::OP_ADV) && bsingle_q);
	assign sts.step_next  = hit && (lv_next < levels_q);
	assign sts.step_new   = hit && is_bottom && (lv_next < LEVEL_LIMIT);
	assign sts.out_free   = !ovalid_q || rsp.ready;

	// level memory
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= lvl_mem_q[lv_q];
		end
		if (cmd.proc) begin
			lvl_mem_q[lv_q] <= {new_fill, new_win};
		end else if (cmd.mknew) begin
			lvl_mem_q[new_addr] <= {2'd1, 4'd0, lab_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= ctle_pkg::WINDOW_RESET;
			tab_lo_q  <= '0;
			tab_hi_q  <= '0;
			ent_v_q   <= '0;
			levels_q  <= '0;
			bsingle_q <= 1'b0;
			fresh_q   <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					ctle_pkg::CFG_WINDOW:      win_q    <= cfg.data[1:0];
					ctle_pkg::CFG_TABLE_LOW:   tab_lo_q <= cfg.data;
					ctle_pkg::CFG_TABLE_HIGH:  tab_hi_q <= cfg.data;
					ctle_pkg::CFG_ENTRY_VALID: ent_v_q  <= cfg.data;
					default: ;
				endcase
			end
			if (cmd.start) begin
				if (req_op == ctle_pkg::OP_CLEAR) begin
					levels_q  <= '0;
					bsingle_q <= 1'b0;
				end
				if (sts.start_walk && (levels_q == '0)) begin
					levels_q <= LCW'(1);
					fresh_q  <= 1'b1;
				end
			end
			if (cmd.proc) begin
				fresh_q <= 1'b0;
				if (is_bottom) begin
					bsingle_q <= (new_fill == 2'd1);
				end
			end
			if (cmd.mknew) begin
				levels_q  <= lv_next + LCW'(1);
				bsingle_q <= 1'b1;
			end
			if (cmd.emit) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lv_q   <= '0;
			prod_q <= 1'b0;
			rlab_q <= 2'd0;
			nm_q   <= 1'b0;
			ovf_q  <= 1'b0;
			nr_q   <= (req_op == ctle_pkg::OP_ADV) && !bsingle_q;
			lab_q  <= (req_op == ctle_pkg::OP_PUSH) ? req_label : blab_q;
		end
		if (cmd.proc) begin
			if (is_bottom) begin
				blab_q <= lab_q;
			end
			if (need_lookup && !hit) begin
				nm_q <= 1'b1;
			end
			if (hit && is_bottom && !(lv_next < LEVEL_LIMIT)) begin
				ovf_q <= 1'b1;
			end
			if (hit) begin
				lab_q <= res;
			end
			if (sts.step_next) begin
				lv_q <= lv_next[AW-1:0];
			end
		end
		if (cmd.mknew) begin
			prod_q <= 1'b1;
			rlab_q <= lab_q;
			blab_q <= lab_q;
		end
		if (cmd.emit) begin
			o_prod_q <= prod_q;
			o_blab_q <= rlab_q;
			o_nm_q   <= nm_q;
			o_ovf_q  <= ovf_q;
			o_nr_q   <= nr_q;
			o_cnt_q  <= cnt_ext[6:0];
		end
	end

	assign rsp.valid          = ovalid_q;
	assign rsp.produced       = o_prod_q;
	assign rsp.bottom_label   = o_blab_q;
	assign rsp.no_match       = o_nm_q;
	assign rsp.level_overflow = o_ovf_q;
	assign rsp.not_ready      = o_nr_q;
	assign rsp.level_count    = o_cnt_q;

`ifndef SYNTH
	a_levels_bound: assert property (@(posedge clk) disable iff (!arst_n)
		levels_q <= LEVEL_LIMIT)
		else $error("level count beyond limit");
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.proc |-> (lv_ext < levels_q))
		else $error("walk reads a level that is not in use");
	a_single_needs_level: assert property (@(posedge clk) disable iff (!arst_n)
		bsingle_q |-> (levels_q != '0))
		else $error("single bottom label flagged with no levels");
	a_new_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mknew |=> (levels_q == $past(levels_q) + LCW'(1)))
		else $error("new level did not grow the triangle by one");
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !(rsp.not_ready && (rsp.produced || rsp.no_match)))
		else $error("ignored advance reports walk results");
`endif

endmodule

// ----- rtl/core/ca_triangle_level_expander.sv -----
// Top level of the cellular-automaton triangle level expander.
// Each item is handled alone. A clear, an unused op or an advance that is not
// ready goes from acceptance straight to the result hand-off. A push (or an
// advance that re-pushes the bottom label) walks down the levels, one level at
// a time: a registered read of the level memory, then the lookup and
// write-back; a further step starts a new bottom level when one is needed.
// The result waits in an output register, so the next item is taken while it
// is still pending; that next item then holds in its last state until the
// pending result is taken.
// Configuration writes are taken in any cycle, with no stall.
module ca_triangle_level_expander #(
	parameter int MAX_LEVELS = 64
) (
	input logic        clk,
	input logic        arst_n,
	ctle_req_if.sink   req,
	ctle_rsp_if.source rsp,
	ctle_cfg_if.sink   cfg
);

	ctle_pkg::ctle_cmd_t cmd;
	ctle_pkg::ctle_sts_t sts;
	logic                ready;

	assign req.ready = ready;

	ctle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ctle_dp #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_op    (req.op),
		.req_label (req.label),
		.cfg       (cfg),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
